[rtl/core/idtv_pkg.sv]
// shared types, constants and calendar helpers for the date text validator
package idtv_pkg;

    // character and length constants
    localparam int unsigned DATE_LEN      = 10;
    localparam int unsigned POS_SAT       = 11;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam logic [7:0]  CHAR_DASH     = 8'h2D;
    localparam logic [7:0]  CHAR_ZERO     = 8'h30;
    localparam logic [7:0]  CHAR_NINE     = 8'h39;
    localparam logic [3:0]  POS_YEAR_END  = 4'd4;
    localparam logic [3:0]  POS_CENT_END  = 4'd2;
    localparam logic [3:0]  POS_DASH_HI   = 4'd7;
    localparam logic [3:0]  POS_LEN       = 4'd10;
    localparam logic [3:0]  POS_MAX       = 4'd11;

    // result status codes
    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_NO_DATE   = 2'd2
    } t_status;

    // one finished string, handed from front to back
    typedef struct packed {
        logic        fmt_ok;
        logic        leap;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
    } t_date_rec;

    // one result item
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        t_status     status;
    } t_result;

    // days in a month, zero for a month out of range
    function automatic logic [4:0] month_len(input logic [6:0] month, input logic leap);
        logic [4:0] len;
        begin
            unique case (month)
                7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
                7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
                7'd2:                                       len = leap ? 5'd29 : 5'd28;
                default:                                    len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

[rtl/core/iso_date_text_validator.sv]
// top level of the date text validator: front, record queue and back
//
//  channel | dir | handshake                    | payload
//  s       | in  | i_s_tvalid / o_s_tready      | i_s_tdata[7:0] char, i_s_tlast final char
//  m       | out | o_m_tvalid / i_m_tready      | o_m_tdata status, year, month, day
//
// one character per cycle; a character is classified and accumulated in the
// cycle it is taken. a result reaches o_m_tvalid after the final character
// has passed through the record queue and then the output register.
// reset is synchronous, active low, and clears the partial string and queue.
// input is held off only when the record queue is full, which needs the
// output side stalled across several finished strings.
module iso_date_text_validator #(
    parameter int unsigned QUEUE_DEPTH = idtv_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  logic        i_s_tlast,   // last_char
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [1:0] status, [15:2] year_value,
                                     // [19:16] month_value, [24:20] day_value
);
    import idtv_pkg::*;

    logic       accept;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    t_date_rec  push_rec;
    t_date_rec  pop_rec;
    t_result    result;

    // input transfer
    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    idtv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_push   (push),
        .o_rec    (push_rec)
    );

    idtv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_rec (push_rec),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_empty    (q_empty),
        .o_pop_rec  (pop_rec)
    );

    idtv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (!q_empty),
        .i_rec       (pop_rec),
        .o_rec_pop   (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_result    (result)
    );

    // pack the result, padded to whole bytes
    assign o_m_tdata = {7'd0, result};

endmodule

[rtl/core/idtv_front.sv]
// front part: takes characters, checks the format and accumulates the fields
module idtv_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_char,
    input  logic                  i_last,
    output logic                  o_push,
    output idtv_pkg::t_date_rec   o_rec
);
    import idtv_pkg::*;

    logic [3:0]  r_pos,   n_pos;
    logic        r_bad,   n_bad;
    logic [13:0] r_year,  n_year;
    logic [6:0]  r_month, n_month;
    logic [6:0]  r_day,   n_day;
    logic [6:0]  r_cent,  n_cent;
    logic [6:0]  r_yrlo,  n_yrlo;
    logic        digit;
    logic [3:0]  dv;

    assign digit = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
    assign dv    = i_char[3:0];

    // classify the character by position and accumulate digits
    always_comb begin
        n_bad   = r_bad;
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_cent  = r_cent;
        n_yrlo  = r_yrlo;
        priority if (r_pos >= POS_LEN) begin
            n_bad = 1'b1;
        end else if (r_pos == POS_YEAR_END || r_pos == POS_DASH_HI) begin
            if (i_char != CHAR_DASH) n_bad = 1'b1;
        end else if (!digit) begin
            n_bad = 1'b1;
        end else if (r_pos < POS_YEAR_END) begin
            n_year = {r_year[10:0], 3'b000} + {r_year[12:0], 1'b0} + {10'd0, dv};
            if (r_pos < POS_CENT_END) begin
                n_cent = {r_cent[3:0], 3'b000} + {r_cent[5:0], 1'b0} + {3'd0, dv};
            end else begin
                n_yrlo = {r_yrlo[3:0], 3'b000} + {r_yrlo[5:0], 1'b0} + {3'd0, dv};
            end
        end else if (r_pos < POS_DASH_HI) begin
            n_month = {r_month[3:0], 3'b000} + {r_month[5:0], 1'b0} + {3'd0, dv};
        end else begin
            n_day = {r_day[3:0], 3'b000} + {r_day[5:0], 1'b0} + {3'd0, dv};
        end
        n_pos = (r_pos < POS_MAX) ? r_pos + 4'd1 : POS_MAX;
    end

    // finished string record; leap year from the two digit pairs
    always_comb begin
        o_push       = i_accept && i_last;
        o_rec.fmt_ok = !n_bad && (n_pos == POS_LEN);
        o_rec.leap   = (n_yrlo == 7'd0) ? (n_cent[1:0] == 2'b00) : (n_yrlo[1:0] == 2'b00);
        o_rec.year   = n_year;
        o_rec.month  = n_month;
        o_rec.day    = n_day;
    end

    // string state, cleared after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_pos   <= '0;
            r_bad   <= 1'b0;
            r_year  <= '0;
            r_month <= '0;
            r_day   <= '0;
            r_cent  <= '0;
            r_yrlo  <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_bad   <= n_bad;
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_cent  <= n_cent;
            r_yrlo  <= n_yrlo;
        end
    end

endmodule

[rtl/core/idtv_queue.sv]
// short queue of finished string records between front and back
module idtv_queue #(
    parameter int unsigned DEPTH = idtv_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  idtv_pkg::t_date_rec   i_push_rec,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output idtv_pkg::t_date_rec   o_pop_rec
);
    import idtv_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_date_rec       r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign o_pop_rec = r_mem[r_rd_ptr];
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_push_rec;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
            if (do_pop)  r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
            if (do_push && !do_pop)      r_count <= r_count + CW'(1);
            else if (do_pop && !do_push) r_count <= r_count - CW'(1);
        end
    end

endmodule

[rtl/core/idtv_back.sv]
// back part: calendar check and registered result output
module idtv_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rec_valid,
    input  idtv_pkg::t_date_rec   i_rec,
    output logic                  o_rec_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output idtv_pkg::t_result     o_result
);
    import idtv_pkg::*;

    logic       r_valid;
    t_result    r_result, n_result;
    logic [4:0] mlen;
    logic       load;

    assign mlen      = month_len(i_rec.month, i_rec.leap);
    assign load      = i_rec_valid && (!r_valid || i_ready);
    assign o_rec_pop = load;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    // status and fields of the next result
    always_comb begin
        n_result = '0;
        priority if (!i_rec.fmt_ok) begin
            n_result.status = ST_MALFORMED;
        end else if (mlen != 5'd0 && i_rec.day != 7'd0 && i_rec.day <= {2'b00, mlen}) begin
            n_result.status = ST_VALID;
            n_result.year   = i_rec.year;
            n_result.month  = i_rec.month[3:0];
            n_result.day    = i_rec.day[4:0];
        end else begin
            n_result.status = ST_NO_DATE;
        end
    end

    // output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) r_result <= n_result;
    end

endmodule

[rtl/core/idtv_checker.sv]
// port level checks of the date text validator, bound to the top level
module idtv_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] o_m_tdata
);
    import idtv_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // status is a known code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] == ST_VALID || o_m_tdata[1:0] == ST_MALFORMED
                        || o_m_tdata[1:0] == ST_NO_DATE))
        else $error("unknown status code");

    // fields are zero unless the date is valid
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] != ST_VALID |-> o_m_tdata[24:2] == 23'd0)
        else $error("fields set on a non valid result");

    // a valid date has month in range, a nonzero day and a year of at most 9999
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] == ST_VALID |->
            o_m_tdata[19:16] >= 4'd1 && o_m_tdata[19:16] <= 4'd12 &&
            o_m_tdata[24:20] >= 5'd1 && o_m_tdata[15:2] <= 14'd9999)
        else $error("valid date out of range");

endmodule

bind iso_date_text_validator idtv_checker u_idtv_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

[dv/tb_top.sv]
// testbench for iso_date_text_validator: streamed date strings checked against a local parser
module tb_top;
    import idtv_pkg::*;

    typedef logic [7:0] t_chars[$];

    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned RANDOM_CHARS   = 1850;

    // parses the character stream the same way the block should and keeps
    // the results still owed by the block
    class date_scoreboard;
        logic [3:0]  char_pos;
        logic        text_bad;
        logic [13:0] year_acc;
        logic [6:0]  month_acc;
        logic [6:0]  day_acc;
        t_result     pending_dates[$];
        int unsigned errors;
        int unsigned seen[3];

        function new();
            clear_string();
            errors = 0;
            seen = '{0, 0, 0};
        endfunction

        function void clear_string();
            char_pos  = '0;
            text_bad  = 1'b0;
            year_acc  = '0;
            month_acc = '0;
            day_acc   = '0;
        endfunction

        function int unsigned outstanding();
            return pending_dates.size();
        endfunction

        // gregorian month length, zero for an impossible month
        function logic [6:0] days_in_month(logic [13:0] y, logic [6:0] m);
            logic leap;
            leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
            case (m)
                7'd2:                       return leap ? 7'd29 : 7'd28;
                7'd4, 7'd6, 7'd9, 7'd11:    return 7'd30;
                7'd1, 7'd3, 7'd5, 7'd7,
                7'd8, 7'd10, 7'd12:         return 7'd31;
                default:                    return 7'd0;
            endcase
        endfunction

        // one accepted input transfer
        function void note_char(logic [7:0] c, logic last);
            logic       is_digit;
            logic [3:0] digit;
            logic [6:0] mlen;
            t_result    r;
            is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            digit    = is_digit ? 4'(c - CHAR_ZERO) : 4'd0;
            if (char_pos >= POS_LEN) begin
                text_bad = 1'b1;
            end else if (char_pos == POS_YEAR_END || char_pos == POS_DASH_HI) begin
                if (c != CHAR_DASH) text_bad = 1'b1;
            end else if (!is_digit) begin
                text_bad = 1'b1;
            end else if (char_pos < POS_YEAR_END) begin
                year_acc = 14'(year_acc * 10 + digit);
            end else if (char_pos < POS_DASH_HI) begin
                month_acc = 7'(month_acc * 10 + digit);
            end else begin
                day_acc = 7'(day_acc * 10 + digit);
            end
            char_pos = (char_pos < POS_MAX) ? char_pos + 4'd1 : POS_MAX;
            if (!last) return;

            r = '0;
            if (text_bad || char_pos != POS_LEN) begin
                r.status = ST_MALFORMED;
            end else begin
                mlen = days_in_month(year_acc, month_acc);
                if (mlen != 0 && day_acc >= 1 && day_acc <= mlen) begin
                    r.status = ST_VALID;
                    r.year   = year_acc;
                    r.month  = 4'(month_acc);
                    r.day    = 5'(day_acc);
                end else begin
                    r.status = ST_NO_DATE;
                end
            end
            pending_dates.push_back(r);
            clear_string();
        endfunction

        // one accepted output transfer
        function void check_result(logic [31:0] data);
            t_result got;
            t_result want;
            got = t_result'(data[24:0]);
            if (pending_dates.size() == 0) begin
                $error("result with none outstanding: status %0d", got.status);
                errors++;
                return;
            end
            want = pending_dates.pop_front();
            seen[int'(want.status)]++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.year !== want.year) begin
                $error("year_value: expected %0d, got %0d", want.year, got.year);
                errors++;
            end
            if (got.month !== want.month) begin
                $error("month_value: expected %0d, got %0d", want.month, got.month);
                errors++;
            end
            if (got.day !== want.day) begin
                $error("day_value: expected %0d, got %0d", want.day, got.day);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] char_code
    logic        i_s_tlast  = 1'b0;    // last_char
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;            // [1:0] status, [15:2] year, [19:16] month, [24:20] day

    date_scoreboard dates = new();
    bit          quiet    = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned n_chars   = 0;
    int unsigned n_strings = 0;
    int unsigned n_holds   = 0;
    int unsigned idle_cycles = 0;

    iso_date_text_validator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ten-character date text, fields taken modulo their digit count
    function automatic t_chars date_text(int unsigned y, int unsigned m, int unsigned d);
        t_chars t;
        t = {CHAR_ZERO + 8'(y / 1000 % 10), CHAR_ZERO + 8'(y / 100 % 10),
             CHAR_ZERO + 8'(y / 10 % 10), CHAR_ZERO + 8'(y % 10), CHAR_DASH,
             CHAR_ZERO + 8'(m / 10 % 10), CHAR_ZERO + 8'(m % 10), CHAR_DASH,
             CHAR_ZERO + 8'(d / 10 % 10), CHAR_ZERO + 8'(d % 10)};
        return t;
    endfunction

    function automatic t_chars text_of(string s);
        t_chars t;
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        return t;
    endfunction

    // send one string, the final character flagged, with random input gaps
    task automatic send_text(input t_chars txt);
        for (int i = 0; i < txt.size(); i++) begin
            if (!quiet && $urandom_range(99) < 6) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= txt[i];
            i_s_tlast  <= (i == txt.size() - 1);
            @(posedge i_clk);
            while (!o_s_tready) @(posedge i_clk);
            dates.note_char(txt[i], i == txt.size() - 1);
            n_chars++;
            @(negedge i_clk);
        end
        n_strings++;
    endtask

    // stop offering input and wait for every owed result
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (dates.outstanding() != 0) @(negedge i_clk);
    endtask

    // output side: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                n_holds++;
            end else begin
                i_m_tready <= quiet || ($urandom_range(99) >= 6);
            end
        end
    end

    // check each output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) dates.check_result(o_m_tdata);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        t_chars      txt;
        int unsigned y, m, d, kind, keep;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // leap rules, year zero, field extremes
        send_text(text_of("2000-02-29"));
        send_text(text_of("1900-02-29"));
        send_text(text_of("2024-02-29"));
        send_text(text_of("2023-02-29"));
        send_text(text_of("0000-02-29"));
        send_text(text_of("9999-12-31"));
        send_text(text_of("0001-01-01"));
        // impossible month and day values
        send_text(text_of("2021-00-10"));
        send_text(text_of("2021-13-01"));
        send_text(text_of("2021-04-31"));
        send_text(text_of("2021-06-00"));
        send_text(text_of("2021-99-99"));
        // wrong length, wrong separators, stray bytes
        send_text(text_of("2021-01-011"));
        send_text(text_of("2021-01-01-2021-01"));
        send_text(text_of("2021-1-1"));
        send_text(text_of("2021/01/01"));
        send_text(text_of("7"));
        send_text({8'h00});
        send_text({8'hFF, 8'h80});

        // sender pauses until the block is empty
        wait_drained();

        // output held off while strings keep coming, so the input backs up
        hold_req = 1'b1;
        repeat (8) send_text(date_text($urandom_range(9999), $urandom_range(1, 12),
                                       $urandom_range(1, 28)));
        wait_drained();

        // random strings: mostly well formed with random fields
        while (n_chars < RANDOM_CHARS) begin
            quiet = (n_strings >= 60 && n_strings < 100);
            case ($urandom_range(3))
                0:       y = $urandom_range(9999);
                1:       y = 100 * $urandom_range(99);
                2:       y = 4 * $urandom_range(2499);
                default: y = $urandom_range(1990, 2030);
            endcase
            if ($urandom_range(9) == 0)      m = $urandom_range(99);
            else if ($urandom_range(3) == 0) m = 2;
            else                             m = $urandom_range(1, 12);
            d = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(0, 31);
            txt  = date_text(y, m, d);
            kind = $urandom_range(99);
            if (kind < 12) begin
                // one position overwritten with any byte
                txt[$urandom_range(9)] = 8'($urandom);
            end else if (kind < 20) begin
                // cut short
                keep = $urandom_range(1, 9);
                while (txt.size() > keep) void'(txt.pop_back());
            end else if (kind < 27) begin
                // run on past ten characters
                repeat ($urandom_range(1, 6)) txt.push_back(($urandom_range(1) == 0) ?
                    CHAR_ZERO + 8'($urandom_range(9)) : 8'($urandom));
            end else if (kind < 33) begin
                // random bytes
                txt = {};
                repeat ($urandom_range(1, 14)) txt.push_back(8'($urandom));
            end
            send_text(txt);
        end
        quiet = 1'b0;

        // drain, then allow the pipeline latency
        wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        repeat (8) @(posedge i_clk);

        $display("tb_top: %0d strings, %0d characters sent", n_strings, n_chars);
        $display("tb_top: results %0d valid, %0d malformed, %0d no such date; %0d hold-off(s)",
                 dates.seen[0], dates.seen[1], dates.seen[2], n_holds);
        if (dates.errors == 0 && dates.outstanding() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
